// ===== sv/ppu_pkg.sv =====
`timescale 1ns / 1ps
// ppu_pkg: shared widths, codes and types for the two-plane pixel plotter.
// No dependencies.
package ppu_pkg;

    localparam int PANEL_WIDTH_DEF  = 176;
    localparam int PANEL_HEIGHT_DEF = 264;
    localparam int PLANE_BYTES_DEF  = 5808;

    localparam int COORD_W    = 11;
    localparam int POS_W      = 10;
    localparam int LIN_W      = 2 * POS_W;
    localparam int IDX_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int PEN_W      = 3;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [ACT_W-1:0] ACT_DRAW = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FILL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    localparam logic [PEN_W-1:0] PEN_WHITE = 3'd0;
    localparam logic [PEN_W-1:0] PEN_BLACK = 3'd1;
    localparam logic [PEN_W-1:0] PEN_COLOR = 3'd2;
    localparam logic [PEN_W-1:0] PEN_INV1  = 3'd3;
    localparam logic [PEN_W-1:0] PEN_INV2  = 3'd4;
    localparam logic [PEN_W-1:0] PEN_INV3  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_COLOR = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_black;
        logic wr_color;
    } plane_ctl_t;

    typedef struct packed {
        logic       in_bounds;
        logic       in_store;
        logic [2:0] bit_pos;
    } coord_t;

endpackage

// ===== sv/two_plane_pixel_plotter_unit.sv =====
`timescale 1ns / 1ps
// Two-plane pixel plotter: sequencer, configuration and plane update logic.
// Depends on ppu_pkg, ppu_coord and ppu_planes.
// Draws pass the map, linear and write states, skipping the write out of bounds or
// beyond the store; valid reads and fills run their own state, others end in idle.
// One beat at a time; busy holds from acceptance to result unless answered in idle.
// Fill and draw time is set by the single port of each plane memory.
// Reset: both planes are swept to zero one byte a cycle, all PLANE_BYTES of them.
// The result strobe done lasts one cycle; the receiver cannot stall.
module two_plane_pixel_plotter_unit
    import ppu_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int PLANE_BYTES  = PLANE_BYTES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ACT_W-1:0]           action,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic [PEN_W-1:0]           pen,
    input  logic                       plane_select,
    input  logic [IDX_W-1:0]           byte_index,
    output logic                       done,
    output logic [BYTE_W-1:0]          read_byte,
    output logic                       accepted,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int ADDR_W = $clog2(PLANE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);
    localparam logic [IDX_W:0]    PB_IDX    = (IDX_W+1)'(PLANE_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_LIN,
        ST_RMW,
        ST_READ,
        ST_FILL
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   sweep_reg;
    logic [ADDR_W-1:0]   sweep_next;
    logic [PEN_W-1:0]    pen_reg;
    logic [PEN_W-1:0]    pen_next;
    logic                sel_reg;
    logic                sel_next;
    logic [BYTE_W-1:0]   fill_b_reg;
    logic [BYTE_W-1:0]   fill_b_next;
    logic [BYTE_W-1:0]   fill_c_reg;
    logic [BYTE_W-1:0]   fill_c_next;
    logic                done_reg;
    logic                done_next;
    logic [BYTE_W-1:0]   rb_reg;
    logic [BYTE_W-1:0]   rb_next;
    logic                acc_reg;
    logic                acc_next;

    logic [1:0]          rotation_reg;
    logic                has_color_reg;

    logic                go;
    logic                read_ok;
    coord_t              coord;
    logic [ADDR_W-1:0]   coord_addr;
    plane_ctl_t          ctl;
    logic [ADDR_W-1:0]   mem_addr;
    logic [BYTE_W-1:0]   wdata_black;
    logic [BYTE_W-1:0]   wdata_color;
    logic [BYTE_W-1:0]   rdata_black;
    logic [BYTE_W-1:0]   rdata_color;
    logic [BYTE_W-1:0]   pix_mask;
    logic [2*BYTE_W-1:0] pix_new;

    function automatic logic [2*BYTE_W-1:0] pixel_rmw(
        input logic [PEN_W-1:0]  p,
        input logic [BYTE_W-1:0] b_in,
        input logic [BYTE_W-1:0] c_in,
        input logic [BYTE_W-1:0] m,
        input logic              cp
    );
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        b = b_in;
        c = c_in;
        case (p)
            PEN_WHITE:
            begin
                b = b & ~m;
                c = c & ~m;
            end
            PEN_BLACK:
            begin
                b = b | m;
                c = c & ~m;
            end
            PEN_COLOR:
            begin
                b = b & ~m;
                c = c | m;
            end
            PEN_INV1:
            begin
                if ((c & m) != '0)
                    c = c & ~m;
                else
                    b = b ^ m;
            end
            PEN_INV2:
            begin
                if ((c & m) != '0)
                begin
                    c = c & ~m;
                    b = b | m;
                end
                else if ((b & m) != '0)
                begin
                    b = b & ~m;
                    c = c | m;
                end
                else
                    b = b | m;
            end
            PEN_INV3:
            begin
                if ((c & m) != '0)
                begin
                    c = c & ~m;
                    b = b | m;
                end
                else if ((b & m) != '0)
                    b = b & ~m;
                else if (cp)
                    c = c | m;
                else
                    b = b | m;
            end
            default:
            begin
                b = b_in;
            end
        endcase
        return {b, c};
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= 2'd0;
            has_color_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                REG_HAS_COLOR: has_color_reg <= cfg_data[0];
                default:       rotation_reg  <= rotation_reg;
            endcase
        end
    end

    ppu_coord #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .PLANE_BYTES  (PLANE_BYTES)
    ) u_coord (
        .clk      (clk),
        .go       (go),
        .rotation (rotation_reg),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .coord    (coord),
        .addr     (coord_addr)
    );

    ppu_planes #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_planes (
        .clk         (clk),
        .ctl         (ctl),
        .addr        (mem_addr),
        .wdata_black (wdata_black),
        .wdata_color (wdata_color),
        .rdata_black (rdata_black),
        .rdata_color (rdata_color)
    );

    assign read_ok  = ({1'b0, byte_index} < PB_IDX) && (!plane_select || has_color_reg);
    assign pix_mask = 8'h80 >> coord.bit_pos;
    assign pix_new  = pixel_rmw(pen_reg, rdata_black,
                                has_color_reg ? rdata_color : '0,
                                pix_mask, has_color_reg);

    // Plane port: address, enables and write data
    always_comb
    begin
        ctl.rd_en    = 1'b0;
        ctl.wr_black = 1'b0;
        ctl.wr_color = 1'b0;
        mem_addr     = coord_addr;
        wdata_black  = pix_new[2*BYTE_W-1:BYTE_W];
        wdata_color  = pix_new[BYTE_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr     = sweep_reg;
                wdata_black  = '0;
                wdata_color  = '0;
                ctl.wr_black = 1'b1;
                ctl.wr_color = 1'b1;
            end
            ST_FILL:
            begin
                mem_addr     = sweep_reg;
                wdata_black  = fill_b_reg;
                wdata_color  = fill_c_reg;
                ctl.wr_black = 1'b1;
                ctl.wr_color = has_color_reg;
            end
            ST_IDLE:
            begin
                mem_addr  = byte_index[ADDR_W-1:0];
                ctl.rd_en = start && (action == ACT_READ) && read_ok;
            end
            ST_LIN:
            begin
                ctl.rd_en = coord.in_bounds && coord.in_store;
            end
            ST_RMW:
            begin
                ctl.wr_black = 1'b1;
                ctl.wr_color = has_color_reg;
            end
            default:
            begin
                ctl.rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        pen_next    = pen_reg;
        sel_next    = sel_reg;
        fill_b_next = fill_b_reg;
        fill_c_next = fill_c_reg;
        done_next   = 1'b0;
        rb_next     = '0;
        acc_next    = 1'b0;
        go          = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    pen_next = pen;
                    sel_next = plane_select;
                    unique case (action)
                        ACT_DRAW:
                        begin
                            go         = 1'b1;
                            state_next = ST_MAP;
                        end
                        ACT_FILL:
                        begin
                            if (pen == PEN_WHITE || pen == PEN_BLACK || pen == PEN_COLOR)
                            begin
                                fill_b_next = (pen == PEN_BLACK) ? 8'hFF : 8'h00;
                                fill_c_next = (pen == PEN_COLOR) ? 8'hFF : 8'h00;
                                sweep_next  = '0;
                                state_next  = ST_FILL;
                            end
                            else
                                done_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            if (read_ok)
                                state_next = ST_READ;
                            else
                                done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_MAP:
            begin
                state_next = ST_LIN;
            end
            ST_LIN:
            begin
                if (coord.in_bounds && coord.in_store)
                    state_next = ST_RMW;
                else
                begin
                    done_next  = 1'b1;
                    acc_next   = coord.in_bounds;
                    state_next = ST_IDLE;
                end
            end
            ST_RMW:
            begin
                done_next  = 1'b1;
                acc_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                acc_next   = 1'b1;
                rb_next    = sel_reg ? rdata_color : rdata_black;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    done_next  = 1'b1;
                    acc_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            done_reg   <= 1'b0;
            rb_reg     <= '0;
            acc_reg    <= 1'b0;
            pen_reg    <= '0;
            sel_reg    <= 1'b0;
            fill_b_reg <= '0;
            fill_c_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            done_reg   <= done_next;
            rb_reg     <= rb_next;
            acc_reg    <= acc_next;
            pen_reg    <= pen_next;
            sel_reg    <= sel_next;
            fill_b_reg <= fill_b_next;
            fill_c_reg <= fill_c_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign read_byte = rb_reg;
    assign accepted  = acc_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(ctl.wr_black || ctl.wr_color))
        else $error("plane written while idle");

    a_payload_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (read_byte != '0 || accepted) |-> done)
        else $error("result payload outside a result beat");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither in progress nor answered");
`endif

endmodule

// ===== sv/ppu_coord.sv =====
`timescale 1ns / 1ps
// ppu_coord: bounds check, rotation and byte/bit addressing in two stages.
// Depends on ppu_pkg.
module ppu_coord
    import ppu_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int PLANE_BYTES  = PLANE_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              go,
    input  logic [1:0]                        rotation,
    input  logic signed [COORD_W-1:0]         pos_x,
    input  logic signed [COORD_W-1:0]         pos_y,
    output coord_t                            coord,
    output logic [$clog2(PLANE_BYTES)-1:0]    addr
);

    localparam int ADDR_W = $clog2(PLANE_BYTES);
    localparam logic [COORD_W-1:0] W_C  = COORD_W'(PANEL_WIDTH);
    localparam logic [COORD_W-1:0] H_C  = COORD_W'(PANEL_HEIGHT);
    localparam logic [COORD_W-1:0] WM1  = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] HM1  = COORD_W'(PANEL_HEIGHT - 1);
    localparam logic [LIN_W-4:0]   PB_C = (LIN_W-3)'(PLANE_BYTES);

    logic [COORD_W-1:0] x_u;
    logic [COORD_W-1:0] y_u;
    logic [COORD_W-1:0] rw;
    logic [COORD_W-1:0] rh;
    logic [COORD_W-1:0] ux_w;
    logic [COORD_W-1:0] uy_w;
    logic               inb_next;

    logic [POS_W-1:0]   ux_reg;
    logic [POS_W-1:0]   uy_reg;
    logic               inb1_reg;
    logic               inb2_reg;
    logic [LIN_W-1:0]   lin_reg;
    logic [LIN_W-1:0]   lin_next;

    assign x_u = $unsigned(pos_x);
    assign y_u = $unsigned(pos_y);
    assign rw  = rotation[0] ? H_C : W_C;
    assign rh  = rotation[0] ? W_C : H_C;
    assign inb_next = !x_u[COORD_W-1] && !y_u[COORD_W-1] && (x_u < rw) && (y_u < rh);

    always_comb
    begin
        case (rotation)
            2'd1:
            begin
                ux_w = WM1 - y_u;
                uy_w = x_u;
            end
            2'd2:
            begin
                ux_w = WM1 - x_u;
                uy_w = HM1 - y_u;
            end
            2'd3:
            begin
                ux_w = y_u;
                uy_w = HM1 - x_u;
            end
            default:
            begin
                ux_w = x_u;
                uy_w = y_u;
            end
        endcase
    end

    assign lin_next = LIN_W'(uy_reg) * LIN_W'(PANEL_WIDTH) + LIN_W'(ux_reg);

    // Stage one: hold mapped coordinates of the accepted beat
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ux_reg   <= ux_w[POS_W-1:0];
            uy_reg   <= uy_w[POS_W-1:0];
            inb1_reg <= inb_next;
        end
    end

    // Stage two: linear pixel number
    always_ff @(posedge clk)
    begin
        lin_reg  <= lin_next;
        inb2_reg <= inb1_reg;
    end

    assign coord.in_bounds = inb2_reg;
    assign coord.in_store  = (lin_reg[LIN_W-1:3] < PB_C);
    assign coord.bit_pos   = lin_reg[2:0];
    assign addr            = lin_reg[ADDR_W+2:3];

endmodule

// ===== sv/ppu_planes.sv =====
`timescale 1ns / 1ps
// ppu_planes: black and colour plane memories, one port each, registered read.
// Depends on ppu_pkg.
module ppu_planes
    import ppu_pkg::*;
#(
    parameter int PLANE_BYTES = PLANE_BYTES_DEF
)
(
    input  logic                              clk,
    input  plane_ctl_t                        ctl,
    input  logic [$clog2(PLANE_BYTES)-1:0]    addr,
    input  logic [BYTE_W-1:0]                 wdata_black,
    input  logic [BYTE_W-1:0]                 wdata_color,
    output logic [BYTE_W-1:0]                 rdata_black,
    output logic [BYTE_W-1:0]                 rdata_color
);

    logic [BYTE_W-1:0] black_mem [PLANE_BYTES];
    logic [BYTE_W-1:0] color_mem [PLANE_BYTES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_black)
        begin
            black_mem[addr] <= wdata_black;
        end
        if (ctl.rd_en)
        begin
            rdata_black <= black_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_color)
        begin
            color_mem[addr] <= wdata_color;
        end
        if (ctl.rd_en)
        begin
            rdata_color <= color_mem[addr];
        end
    end

endmodule

// ===== sim/two_plane_pixel_plotter_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_plane_pixel_plotter_unit: draws, fills and plane reads
// under every rotation, with and without the colour plane. Depends on ppu_pkg.
module two_plane_pixel_plotter_unit_test;
    import ppu_pkg::*;

    localparam int W           = PANEL_WIDTH_DEF;
    localparam int H           = PANEL_HEIGHT_DEF;
    localparam int NBYTES      = PLANE_BYTES_DEF;
    localparam int IDLE_PCT    = 31;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 150;
    localparam int TAIL_CYCLES = 20;
    localparam int WIN         = 16;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam logic [PEN_W-1:0] PEN_NOP6 = 3'd6;
    localparam logic [PEN_W-1:0] PEN_NOP7 = 3'd7;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic                  is_cfg;
        logic                  no_gap;
        logic [ACT_W-1:0]      act;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [PEN_W-1:0]      pen;
        logic                  sel;
        logic [IDX_W-1:0]      idx;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rbyte;
        logic              acc;
    } reply_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic [ACT_W-1:0]           action       = ACT_DRAW;
    logic signed [COORD_W-1:0]  pos_x        = '0;
    logic signed [COORD_W-1:0]  pos_y        = '0;
    logic [PEN_W-1:0]           pen          = PEN_WHITE;
    logic                       plane_select = 1'b0;
    logic [IDX_W-1:0]           byte_index   = '0;
    logic                       done;
    logic [BYTE_W-1:0]          read_byte;
    logic                       accepted;
    logic                       cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = REG_ROTATION;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;

    logic [BYTE_W-1:0] black_m [NBYTES];
    logic [BYTE_W-1:0] color_m [NBYTES];
    logic [1:0]        rot_m;
    logic              color_en_m;

    entry_t beat_q[$];
    reply_t reply_q[$];
    int     fail_cnt     = 0;
    int     quiet_cycles = 0;

    two_plane_pixel_plotter_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pen          (pen),
        .plane_select (plane_select),
        .byte_index   (byte_index),
        .done         (done),
        .read_byte    (read_byte),
        .accepted     (accepted),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int pixel_number(input logic [1:0] rot, input int x, input int y);
        int rw;
        int rh;
        int ux;
        int uy;
        rw = rot[0] ? H : W;
        rh = rot[0] ? W : H;
        if (x < 0 || x >= rw || y < 0 || y >= rh)
            return -1;
        case (rot)
            ROT_90:  begin ux = W - 1 - y; uy = x;         end
            ROT_180: begin ux = W - 1 - x; uy = H - 1 - y; end
            ROT_270: begin ux = y;         uy = H - 1 - x; end
            default: begin ux = x;         uy = y;         end
        endcase
        return uy * W + ux;
    endfunction

    function automatic reply_t panel_update(input entry_t e);
        reply_t            r;
        int                lin;
        int                bi;
        logic [BYTE_W-1:0] m;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        r.rbyte = '0;
        r.acc   = 1'b0;
        case (e.act)
            ACT_DRAW: begin
                lin = pixel_number(rot_m, int'($signed(e.x)), int'($signed(e.y)));
                if (lin >= 0) begin
                    r.acc = 1'b1;
                    bi = lin / 8;
                    if (bi < NBYTES) begin
                        m = 8'h80 >> (lin % 8);
                        b = black_m[bi];
                        c = color_en_m ? color_m[bi] : '0;
                        case (e.pen)
                            PEN_WHITE: begin b &= ~m; c &= ~m; end
                            PEN_BLACK: begin b |= m;  c &= ~m; end
                            PEN_COLOR: begin b &= ~m; c |= m;  end
                            PEN_INV1: begin
                                if ((c & m) != 0) c &= ~m;
                                else b ^= m;
                            end
                            PEN_INV2: begin
                                if ((c & m) != 0) begin c &= ~m; b |= m; end
                                else if ((b & m) != 0) begin b &= ~m; c |= m; end
                                else b |= m;
                            end
                            PEN_INV3: begin
                                if ((c & m) != 0) begin c &= ~m; b |= m; end
                                else if ((b & m) != 0) b &= ~m;
                                else if (color_en_m) c |= m;
                                else b |= m;
                            end
                            default: ;
                        endcase
                        black_m[bi] = b;
                        if (color_en_m)
                            color_m[bi] = c;
                    end
                end
            end
            ACT_FILL: begin
                if (e.pen <= PEN_COLOR) begin
                    for (int i = 0; i < NBYTES; i++) begin
                        black_m[i] = (e.pen == PEN_BLACK) ? 8'hFF : 8'h00;
                        if (color_en_m)
                            color_m[i] = (e.pen == PEN_COLOR) ? 8'hFF : 8'h00;
                    end
                    r.acc = 1'b1;
                end
            end
            ACT_READ: begin
                if (e.idx < NBYTES && (!e.sel || color_en_m)) begin
                    r.rbyte = e.sel ? color_m[e.idx] : black_m[e.idx];
                    r.acc   = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic entry_t rand_beat(input logic [ACT_W-1:0] act);
        entry_t e;
        e.is_cfg  = 1'b0;
        e.no_gap  = 1'b0;
        e.act     = act;
        e.x       = COORD_W'($urandom_range(0, 2047));
        e.y       = COORD_W'($urandom_range(0, 2047));
        e.pen     = PEN_W'($urandom_range(0, 7));
        e.sel     = 1'($urandom_range(0, 1));
        e.idx     = IDX_W'($urandom_range(0, 8191));
        e.reg_idx = REG_ROTATION;
        e.reg_val = '0;
        return e;
    endfunction

    function automatic entry_t draw_beat(input int x, input int y, input logic [PEN_W-1:0] p);
        entry_t e;
        e     = rand_beat(ACT_DRAW);
        e.x   = COORD_W'(x);
        e.y   = COORD_W'(y);
        e.pen = p;
        return e;
    endfunction

    function automatic entry_t read_beat(input logic s, input int i);
        entry_t e;
        e     = rand_beat(ACT_READ);
        e.sel = s;
        e.idx = IDX_W'(i);
        return e;
    endfunction

    function automatic entry_t fill_beat(input logic [PEN_W-1:0] p);
        entry_t e;
        e     = rand_beat(ACT_FILL);
        e.pen = p;
        return e;
    endfunction

    function automatic entry_t reg_write(input logic [CFG_IDX_W-1:0] ri, input int v);
        entry_t e;
        e         = rand_beat(ACT_NONE);
        e.is_cfg  = 1'b1;
        e.reg_idx = ri;
        e.reg_val = CFG_DATA_W'(v);
        return e;
    endfunction

    // driver: hold a beat until taken; register writes only once the block is quiet
    always @(posedge clk) begin
        entry_t hd;
        logic   fired;
        logic   go;
        logic   do_cfg;
        if (!rst_n) begin
            start  <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            fired  = start && !busy;
            go     = 1'b0;
            do_cfg = 1'b0;
            if (fired) begin
                hd = beat_q.pop_front();
                reply_q.push_back(panel_update(hd));
            end
            if (beat_q.size() != 0) begin
                hd = beat_q[0];
                if (start && !fired)
                    go = 1'b1;
                else if (hd.is_cfg)
                    do_cfg = !start && !busy &&
                             (reply_q.size() == 0 || (reply_q.size() == 1 && done === 1'b1));
                else
                    go = hd.no_gap || $urandom_range(0, 99) >= IDLE_PCT;
            end
            if (do_cfg) begin
                void'(beat_q.pop_front());
                if (hd.reg_idx == REG_ROTATION)
                    rot_m = hd.reg_val[1:0];
                else
                    color_en_m = hd.reg_val[0];
                cfg_index <= hd.reg_idx;
                cfg_data  <= hd.reg_val;
            end
            cfg_we <= do_cfg;
            start  <= go;
            if (go) begin
                action       <= hd.act;
                pos_x        <= hd.x;
                pos_y        <= hd.y;
                pen          <= hd.pen;
                plane_select <= hd.sel;
                byte_index   <= hd.idx;
            end
        end
    end

    always @(posedge clk) begin
        reply_t want;
        if (rst_n && done === 1'b1) begin
            if (reply_q.size() == 0) begin
                $error("unexpected result beat: read_byte %0h accepted %0b",
                       read_byte, accepted);
                fail_cnt++;
            end else begin
                want = reply_q.pop_front();
                if (read_byte !== want.rbyte) begin
                    $error("read_byte: expected %0h, got %0h", want.rbyte, read_byte);
                    fail_cnt++;
                end
                if (accepted !== want.acc) begin
                    $error("accepted: expected %0b, got %0b", want.acc, accepted);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("two_plane_pixel_plotter_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        entry_t     e;
        int         recent[$];
        int         lin;
        int         r;
        int         rw;
        int         rh;
        int         wx;
        int         wy;
        logic [1:0] rot;
        logic       color_on;

        for (int i = 0; i < NBYTES; i++) begin
            black_m[i] = '0;
            color_m[i] = '0;
        end
        rot_m      = ROT_0;
        color_en_m = 1'b1;

        beat_q.push_back(reg_write(REG_ROTATION, ROT_0));
        beat_q.push_back(reg_write(REG_HAS_COLOR, 1));
        beat_q.push_back(read_beat(1'b0, 0));
        beat_q.push_back(read_beat(1'b1, 8191));
        beat_q.push_back(read_beat(1'b0, NBYTES));
        beat_q.push_back(draw_beat(0, 0, PEN_BLACK));
        beat_q.push_back(draw_beat(W - 1, H - 1, PEN_COLOR));
        beat_q.push_back(draw_beat(-1024, 0, PEN_BLACK));
        beat_q.push_back(draw_beat(1023, 1023, PEN_BLACK));
        beat_q.push_back(draw_beat(W, 0, PEN_BLACK));
        // step the INV2 and INV3 pens three times each on one pixel
        for (int k = 0; k < 3; k++)
            beat_q.push_back(draw_beat(2, 0, PEN_INV2));
        for (int k = 0; k < 3; k++)
            beat_q.push_back(draw_beat(3, 0, PEN_INV3));
        beat_q.push_back(draw_beat(0, 0, PEN_INV1));
        beat_q.push_back(draw_beat(W - 1, H - 1, PEN_INV1));
        beat_q.push_back(draw_beat(4, 0, PEN_NOP6));
        beat_q.push_back(draw_beat(5, 0, PEN_NOP7));
        beat_q.push_back(read_beat(1'b0, 0));
        beat_q.push_back(read_beat(1'b1, 0));
        beat_q.push_back(rand_beat(ACT_NONE));
        beat_q.push_back(fill_beat(PEN_NOP7));
        beat_q.push_back(fill_beat(PEN_COLOR));
        beat_q.push_back(fill_beat(PEN_BLACK));
        beat_q.push_back(read_beat(1'b0, NBYTES - 1));

        for (int p = 0; p < PHASES; p++) begin
            rot      = 2'(p % 4);
            color_on = (p % 3) != 2;
            beat_q.push_back(reg_write(REG_ROTATION, rot));
            beat_q.push_back(reg_write(REG_HAS_COLOR, color_on));
            rw = rot[0] ? H : W;
            rh = rot[0] ? W : H;
            wx = $urandom_range(0, rw - WIN);
            wy = $urandom_range(0, rh - WIN);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                r = $urandom_range(0, 999);
                if (r < 12) begin
                    e = fill_beat(PEN_W'($urandom_range(0, 7)));
                end else if (r < 40) begin
                    e = rand_beat(ACT_NONE);
                end else if (r < 330) begin
                    e = rand_beat(ACT_READ);
                    r = $urandom_range(0, 9);
                    if (r < 7 && recent.size() != 0)
                        e.idx = IDX_W'(recent[$urandom_range(0, recent.size() - 1)]);
                    else if (r < 9)
                        e.idx = IDX_W'($urandom_range(0, NBYTES - 1));
                end else begin
                    e = rand_beat(ACT_DRAW);
                    if ($urandom_range(0, 99) < 85) begin
                        e.x = COORD_W'(wx + $urandom_range(0, WIN - 1));
                        e.y = COORD_W'(wy + $urandom_range(0, WIN - 1));
                    end
                    lin = pixel_number(rot, int'($signed(e.x)), int'($signed(e.y)));
                    if (lin >= 0) begin
                        recent.push_back(lin / 8);
                        if (recent.size() > 32)
                            void'(recent.pop_front());
                    end
                end
                e.no_gap = (p == 4);
                beat_q.push_back(e);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_q.size() != 0 || reply_q.size() != 0 || start)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("two_plane_pixel_plotter_unit test passed");
        else
            $display("two_plane_pixel_plotter_unit test failed");
        $finish;
    end

endmodule
